### hw/rtl/matrix_multiply_add_assert.svh
// assertion macros for the matrix multiply-add block
`ifndef MATRIX_MULTIPLY_ADD_ASSERT_SVH
`define MATRIX_MULTIPLY_ADD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MMA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MMA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mma_pkg.sv
package mma_pkg;

   // matrix side and derived sizes
   localparam int DIM    = 4;
   localparam int CELLS  = DIM * DIM;
   localparam int POS_W  = $clog2(CELLS);
   localparam int IDX_W  = $clog2(DIM);

   // element, product and result widths
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int D_W    = 35;

endpackage

### hw/rtl/mma_ram.sv
module mma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/matrix_multiply_add.sv
// channel  direction  payload                               transfer
// req      in         req_a_value, req_b_value, req_c_value  req_valid & !req_stall
// rsp      out        rsp_d_value, rsp_last                  rsp_valid & !rsp_stall
//
// loading takes one cycle per item; req_stall is high while results are computed
// each result element is built from one ram read and one multiply per cycle
// over the DIM terms of its dot product, then a three-stage multiply-accumulate drain
// elements are computed one at a time; each starts once the last is handed off
// reset is synchronous and active high; the stores keep no reset value
// rsp_stall holds the output register and the next element waits behind it
module matrix_multiply_add
   import mma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [VAL_W-1:0] req_a_value,
   input  logic signed [VAL_W-1:0] req_b_value,
   input  logic signed [VAL_W-1:0] req_c_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [D_W-1:0]   rsp_d_value,
   output logic                    rsp_last
);

`include "matrix_multiply_add_assert.svh"

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_CALC = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [POS_W-1:0] load_pos_ff, load_pos_in;
   logic [POS_W-1:0] a_addr_ff, a_addr_in;
   logic [POS_W-1:0] b_addr_ff, b_addr_in;
   logic [POS_W-1:0] elem_ff, elem_in;
   logic [POS_W-1:0] row_base_ff, row_base_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] k_ff, k_in;

   logic p1_valid_ff, p1_first_ff, p1_end_ff;
   logic p2_valid_ff, p2_first_ff, p2_end_ff;
   logic res_ready_ff, res_ready_in;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0]  c_ff;
   logic signed [D_W-1:0]    acc_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [D_W-1:0]  rsp_d_value_ff;
   logic                   rsp_last_ff;

   logic [VAL_W-1:0] a_rd, b_rd, c_rd;
   logic             load_xfer, load_end, issue, issue_end;
   logic             out_free, move, elem_end;

   // handshake terms
   assign req_stall = (state_ff != ST_LOAD);
   assign load_xfer = req_valid && (state_ff == ST_LOAD);
   assign load_end  = (load_pos_ff == POS_W'(CELLS - 1));
   assign issue     = (state_ff == ST_CALC);
   assign issue_end = (k_ff == IDX_W'(DIM - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = (state_ff == ST_HOLD) && res_ready_ff && out_free;
   assign elem_end  = (elem_ff == POS_W'(CELLS - 1));

   // operand stores
   mma_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_a_ram (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (load_pos_ff),
      .wr_data (req_a_value),
      .rd_addr (a_addr_ff),
      .rd_data (a_rd)
   );

   mma_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_b_ram (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (load_pos_ff),
      .wr_data (req_b_value),
      .rd_addr (b_addr_ff),
      .rd_data (b_rd)
   );

   mma_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_c_ram (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (load_pos_ff),
      .wr_data (req_c_value),
      .rd_addr (elem_ff),
      .rd_data (c_rd)
   );

   // sequencer: load positions, issue dot-product reads, hand off results
   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      elem_in     = elem_ff;
      row_base_in = row_base_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_xfer) begin
               if (load_end) begin
                  load_pos_in = '0;
                  state_in    = ST_CALC;
               end else begin
                  load_pos_in = load_pos_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            a_addr_in = a_addr_ff + 1'b1;
            b_addr_in = b_addr_ff + POS_W'(DIM);
            if (issue_end) begin
               k_in     = '0;
               state_in = ST_HOLD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (move) begin
               if (elem_end) begin
                  elem_in     = '0;
                  col_in      = '0;
                  row_base_in = '0;
                  a_addr_in   = '0;
                  b_addr_in   = '0;
                  state_in    = ST_LOAD;
               end else begin
                  elem_in = elem_ff + 1'b1;
                  if (col_ff == IDX_W'(DIM - 1)) begin
                     col_in      = '0;
                     row_base_in = row_base_ff + POS_W'(DIM);
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  a_addr_in = row_base_in;
                  b_addr_in = POS_W'(col_in);
                  state_in  = ST_CALC;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // result handoff flags
   always_comb begin
      res_ready_in = res_ready_ff;
      if (move) begin
         res_ready_in = 1'b0;
      end else if (p2_valid_ff && p2_end_ff) begin
         res_ready_in = 1'b1;
      end
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_pos_ff  <= '0;
         a_addr_ff    <= '0;
         b_addr_ff    <= '0;
         elem_ff      <= '0;
         row_base_ff  <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         res_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         a_addr_ff    <= a_addr_in;
         b_addr_ff    <= b_addr_in;
         elem_ff      <= elem_in;
         row_base_ff  <= row_base_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         res_ready_ff <= res_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // multiply-accumulate pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      p1_first_ff <= (k_ff == '0);
      p1_end_ff   <= issue_end;
      p2_first_ff <= p1_first_ff;
      p2_end_ff   <= p1_end_ff;
      prod_ff     <= $signed(a_rd) * $signed(b_rd);
      if (p1_valid_ff && p1_first_ff) begin
         c_ff <= $signed(c_rd);
      end
      if (p2_valid_ff) begin
         acc_ff <= (p2_first_ff ? D_W'(c_ff) : acc_ff) + D_W'(prod_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_d_value_ff <= acc_ff;
         rsp_last_ff    <= elem_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_d_value = rsp_d_value_ff;
   assign rsp_last    = rsp_last_ff;

   // checks
   `MMA_ASSERT_IMP(a_no_issue_in_load, p1_valid_ff, state_ff != ST_LOAD,
      "read data in flight while loading")
   `MMA_ASSERT_IMP(a_pos_only_in_load, load_pos_ff != '0, state_ff == ST_LOAD,
      "load position moved outside loading")
   `MMA_ASSERT_NXT(a_calc_after_load, load_xfer && load_end,
      state_ff == ST_CALC && k_ff == '0 && elem_ff == '0,
      "compute did not start at the first element")
   `MMA_ASSERT_NXT(a_result_kept, res_ready_ff && !move, res_ready_ff,
      "finished result dropped before handoff")

endmodule
